>>> rtl/core/wpo_pkg.sv
package wpo_pkg;

  localparam int SINE_BITS_DEF = 10;
  localparam int EXP_BITS_DEF  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 37;   // signed operand width of the shared multiplier
  localparam int RES_W      = 48;   // signed result width after the shift

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] LN2_Q32    = 64'd2977044472;

  localparam logic signed [31:0] K_484   = 32'sd81201725;
  localparam logic signed [31:0] K_13    = 32'sd21810381;
  localparam logic signed [31:0] K_18    = 32'sd30198989;
  localparam logic signed [31:0] K_019   = 32'sd3187671;
  localparam logic signed [31:0] C4_Q16  = 32'sd17145895;
  localparam logic [30:0]        FMAX_Q16 = 31'd1310720000;
  localparam logic signed [31:0] DIV6_M  = 32'sd5592406;   // ceil(2^25 / 6)
  localparam logic signed [23:0] DIV6_BIAS = 24'sd1572864; // 6 * 2^18

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COARSE    = 3'd0,
    REG_SEMITONE  = 3'd1,
    REG_FINE      = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_PERIOD    = 3'd4,
    REG_SYNC_LOW  = 3'd5,
    REG_SYNC_HIGH = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef enum logic [4:0] {
    OP_DIV6,
    OP_RD_E0,
    OP_RD_E1,
    OP_INTERP,
    OP_BASE,
    OP_INC,
    OP_RD_SINE,
    OP_SQ_A,
    OP_CUBE_A,
    OP_GAIN_A,
    OP_SAW_A,
    OP_SAW_B,
    OP_PH2,
    OP_ARG,
    OP_RD_PULSE,
    OP_SQ_B,
    OP_CUBE_B,
    OP_GAIN_B,
    OP_TRI_A,
    OP_TRI_B
  } op_t;

  typedef struct packed {
    logic signed [15:0] octave_cv;
    logic signed [15:0] pitch_cv;
    logic signed [15:0] width_cv;
    logic signed [15:0] sync_cv;
  } wpo_in_t;

  typedef struct packed {
    logic signed [15:0] sine_out;
    logic signed [15:0] saw_out;
    logic signed [15:0] pulse_out;
    logic signed [15:0] triangle_out;
  } wpo_out_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic [5:0]              sh;
    logic                    rnd;  // 1: round half away from zero, 0: floor
  } wpo_mul_req_t;

  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
    case (k)
      1:       return t / 64'd6;
      2:       return t / 64'd20;
      3:       return t / 64'd42;
      4:       return t / 64'd72;
      5:       return t / 64'd110;
      6:       return t / 64'd156;
      7:       return t / 64'd210;
      8:       return t / 64'd272;
      9:       return t / 64'd342;
      default: return t / 64'd420;
    endcase
  endfunction

  function automatic logic [63:0] exp_div(input logic [63:0] t, input int k);
    case (k)
      1:       return t;
      2:       return t / 64'd2;
      3:       return t / 64'd3;
      4:       return t / 64'd4;
      5:       return t / 64'd5;
      6:       return t / 64'd6;
      7:       return t / 64'd7;
      8:       return t / 64'd8;
      9:       return t / 64'd9;
      10:      return t / 64'd10;
      11:      return t / 64'd11;
      12:      return t / 64'd12;
      13:      return t / 64'd13;
      14:      return t / 64'd14;
      15:      return t / 64'd15;
      default: return t / 64'd16;
    endcase
  endfunction

  // sin(2*pi*j/2^bits) in Q1.30, quarter wave by series, rest by symmetry
  function automatic logic signed [31:0] sine_entry(input int j, input int bits);
    logic [63:0]        th;
    logic [63:0]        t;
    logic signed [63:0] s;
    int                 qn;
    int                 quad;
    int                 jj;
    int                 k;
    qn   = 1 << (bits - 2);
    quad = j >> (bits - 2);
    jj   = j & (qn - 1);
    if ((quad & 1) != 0) jj = qn - jj;
    th = (TWO_PI_Q30 * 64'(jj)) >> bits;
    t  = th;
    s  = signed'(th);
    for (k = 1; k <= 10; k++) begin
      t = (t * th) >> 30;
      t = (t * th) >> 30;
      t = taylor_div(t, k);
      if ((k & 1) != 0) s = s - signed'(t);
      else s = s + signed'(t);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return (quad >= 2) ? 32'(-s) : 32'(s);
  endfunction

  // 2^(i/2^bits) in Q.32
  function automatic logic [33:0] exp_entry(input int i, input int bits);
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] t;
    int          k;
    y = (LN2_Q32 * 64'(i)) >> bits;
    s = 64'd1 << 32;
    t = 64'd1 << 32;
    for (k = 1; k <= 16; k++) begin
      t = exp_div((t * y) >> 32, k);
      s = s + t;
    end
    return 34'(s);
  endfunction

endpackage

>>> rtl/core/wpo_mul.sv
module wpo_mul import wpo_pkg::*; (
  input  logic                    clk,
  input  wpo_mul_req_t            req,
  output logic signed [RES_W-1:0] res
);

  localparam int PW = 2 * MUL_W;

  logic [MUL_W-1:0] mag_a;
  logic [MUL_W-1:0] mag_b;
  logic [PW-1:0]    prod_r;
  logic             neg_r;
  logic [5:0]       sh_r;
  logic             rnd_r;
  logic [PW-1:0]    rmag;
  logic signed [PW:0] sprod;
  logic signed [RES_W-1:0] res_nxt;

  assign mag_a = req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
  assign mag_b = req.b[MUL_W-1] ? MUL_W'(-req.b) : MUL_W'(req.b);

  // stage 1: magnitude product
  always_ff @(posedge clk) begin
    prod_r <= mag_a * mag_b;
    neg_r  <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
    sh_r   <= req.sh;
    rnd_r  <= req.rnd;
  end

  // stage 2: sign, round or floor, scale
  always_comb begin
    rmag    = (prod_r + (PW'(1) << (sh_r - 6'd1))) >> sh_r;
    sprod   = neg_r ? -signed'({1'b0, prod_r}) : signed'({1'b0, prod_r});
    if (rnd_r) begin
      res_nxt = neg_r ? -RES_W'(rmag) : RES_W'(rmag);
    end else begin
      res_nxt = RES_W'(sprod >>> sh_r);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule

>>> rtl/core/wpo_tables.sv
module wpo_tables import wpo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
  parameter int EXP_TABLE_BITS  = EXP_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-1:0] sine_addr,
  input  logic [EXP_TABLE_BITS:0]    exp_addr,
  output logic signed [31:0]         sine_q,
  output logic [33:0]                exp_q
);

  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int EXP_N  = (1 << EXP_TABLE_BITS) + 1;

  logic signed [31:0] sine_tab [SINE_N];
  logic [33:0]        exp_tab  [EXP_N];

  for (genvar g = 0; g < SINE_N; g++) begin : g_sine
    assign sine_tab[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  for (genvar g = 0; g < EXP_N; g++) begin : g_exp
    assign exp_tab[g] = exp_entry(g, EXP_TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    sine_q <= sine_tab[sine_addr];
    exp_q  <= exp_tab[exp_addr];
  end

endmodule

>>> rtl/core/waveshaped_phase_oscillator.sv
// Channel   Dir  Handshake                Payload
// in        in   in_valid / in_ready      in_data  (octave, pitch, width, sync cv)
// out       out  out_valid / out_ready    out_data (sine, saw, pulse, triangle)
// cfg       in   cfg_we                   cfg_index, cfg_wdata
//
// Each sample runs a transfer, twenty micro-ops through the shared two-stage
// multiplier and the registered tables, and a hold state that hands the result
// to the output register once it is free. in_ready is high only when idle.
// The output register lets the next sample start while a result waits.
// rst_n is synchronous: control state, trigger and phase clear, registers take
// their defaults. The tables are constant, so no clearing pass is needed.
module waveshaped_phase_oscillator import wpo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
  parameter int EXP_TABLE_BITS  = EXP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wpo_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wpo_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int EXP_SH = 16 - EXP_TABLE_BITS;
  localparam int SB     = SINE_TABLE_BITS;

  // configuration
  logic signed [14:0] coarse_r;
  logic signed [15:0] semi_r;
  logic signed [12:0] fine_r;
  logic [12:0]        knob_r;
  logic [23:0]        period_r;
  logic signed [15:0] sync_low_r;
  logic signed [15:0] sync_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_r    <= '0;
      semi_r      <= '0;
      fine_r      <= '0;
      knob_r      <= 13'd2048;
      period_r    <= 24'd1558264;
      sync_low_r  <= '0;
      sync_high_r <= 16'sd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COARSE:    coarse_r    <= cfg_wdata[14:0];
        REG_SEMITONE:  semi_r      <= cfg_wdata[15:0];
        REG_FINE:      fine_r      <= cfg_wdata[12:0];
        REG_WIDTH:     knob_r      <= cfg_wdata[12:0];
        REG_PERIOD:    period_r    <= cfg_wdata;
        REG_SYNC_LOW:  sync_low_r  <= cfg_wdata[15:0];
        REG_SYNC_HIGH: sync_high_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t   state_r, state_nxt;
  op_t      op_r, op_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic     cap;
  logic     load_out;
  logic     in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign cap      = (state_r == ST_RUN) && (sub_r == 2'd2);
  assign load_out = (state_r == ST_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_DIV6;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sub_nxt   = sub_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          op_nxt    = OP_DIV6;
          sub_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (sub_r == 2'd2) begin
          sub_nxt = '0;
          if (op_r == OP_TRI_B) state_nxt = ST_HOLD;
          else op_nxt = op_t'(op_r + 5'd1);
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // input capture and sync trigger
  wpo_in_t in_r;
  logic    armed_r;
  logic    fire;
  logic [31:0] phase_r;

  always_comb begin
    fire = 1'b0;
    if (!armed_r && (in_data.sync_cv >= sync_high_r)) fire = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (in_xfer) begin
      // release is tested first, so crossed levels behave as given
      if (armed_r) begin
        if (in_data.sync_cv <= sync_low_r) armed_r <= 1'b0;
      end else if (fire) begin
        armed_r <= 1'b1;
      end
    end
  end

  // shared units
  wpo_mul_req_t            mreq;
  logic signed [RES_W-1:0] mres;
  logic [SB-1:0]           sine_addr;
  logic [EXP_TABLE_BITS:0] exp_addr;
  logic signed [31:0]      sine_q;
  logic [33:0]             exp_q;

  wpo_mul u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  wpo_tables #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .EXP_TABLE_BITS  (EXP_TABLE_BITS)
  ) u_tables (
    .clk       (clk),
    .sine_addr (sine_addr),
    .exp_addr  (exp_addr),
    .sine_q    (sine_q),
    .exp_q     (exp_q)
  );

  // working registers
  logic signed [20:0]      tw_r;
  logic [33:0]             e0_r;
  logic [33:0]             e1_r;
  logic [33:0]             mant_r;
  logic [26:0]             base_r;
  logic signed [25:0]      v_r;
  logic signed [RES_W-1:0] t_r;
  logic [29:0]             arg_r;
  logic [15:0]             sine_r;
  logic [15:0]             saw_r;
  logic [15:0]             pulse_r;
  logic [15:0]             tri_r;

  function automatic logic signed [25:0] rnd6(input logic signed [31:0] x);
    logic [31:0] m;
    logic [25:0] r;
    m = x[31] ? 32'(-x) : 32'(x);
    r = 26'((m + 32'd32) >> 6);
    return x[31] ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic [15:0] to_out(input logic signed [49:0] x);
    logic [49:0]        m;
    logic [49:0]        r;
    logic signed [50:0] rs;
    m  = x[49] ? 50'(-x) : 50'(x);
    r  = (m + 50'd4096) >> 13;
    rs = x[49] ? -signed'({1'b0, r}) : signed'({1'b0, r});
    if (rs > 51'sd32767) return 16'h7FFF;
    if (rs < -51'sd32768) return 16'h8000;
    return rs[15:0];
  endfunction

  // pitch path
  logic signed [18:0] tw_sum;
  logic signed [23:0] div_u;
  logic signed [17:0] base11;
  logic signed [24:0] pitch16;
  logic signed [8:0]  ip;
  logic [15:0]        frac;
  logic [EXP_TABLE_BITS-1:0] exp_idx;
  logic [EXP_SH-1:0]  exp_lo;
  logic [32:0]        base_up;
  logic [8:0]         nsh;
  logic [30:0]        freq;

  assign tw_sum  = 19'(in_r.pitch_cv) + 19'(semi_r) + 19'(fine_r);
  assign div_u   = (24'(tw_sum) <<< 4) + 24'sd3 + DIV6_BIAS;
  assign base11  = 18'sd2048 + 18'(coarse_r) + 18'(in_r.octave_cv);
  assign pitch16 = (25'(base11) <<< 5) + 25'(tw_r);
  assign ip      = pitch16[24:16];
  assign frac    = pitch16[15:0];
  assign exp_idx = frac[15:EXP_SH];
  assign exp_lo  = frac[EXP_SH-1:0];
  assign base_up = 33'(base_r) << ip[2:0];
  assign nsh     = 9'(-ip);

  always_comb begin
    if (!ip[8] && (ip >= 9'sd7)) begin
      freq = FMAX_Q16;
    end else if (!ip[8]) begin
      freq = (base_up > 33'(FMAX_Q16)) ? FMAX_Q16 : 31'(base_up);
    end else if (nsh >= 9'd63) begin
      freq = '0;
    end else begin
      freq = 31'(base_r >> nsh);
    end
  end

  assign exp_addr = (op_r == OP_RD_E1) ? ({1'b0, exp_idx} + 1'b1) : {1'b0, exp_idx};

  // waveform path
  logic [25:0]        ph;
  logic signed [27:0] ph_s;
  logic signed [27:0] saw_v;
  logic signed [13:0] knob_s;
  logic signed [17:0] wsum;
  logic signed [31:0] xw;
  logic signed [27:0] tri_v;
  logic signed [33:0] v50;
  logic signed [25:0] s24;
  logic signed [31:0] pv;
  logic signed [25:0] pv_clamp;
  logic [34:0]        phase_sum;

  assign ph     = phase_r[31:6];
  assign ph_s   = signed'({2'b00, ph});
  assign saw_v  = 28'sd16777216 - (ph_s <<< 1);
  assign knob_s = signed'({1'b0, knob_r});
  assign wsum   = 18'(knob_s) + 18'(in_r.width_cv);
  assign xw     = (32'(wsum) <<< 13) + K_019;
  assign v50    = 34'(tri_v) * 34'sd50;
  assign s24    = rnd6(sine_q);
  assign pv     = 32'sd335544320 - (32'(s24) * 32'sd40);
  assign phase_sum = 35'(phase_r) + 35'(mres[33:0]);

  always_comb begin
    if (ph_s <= 28'sd4194304) tri_v = ph_s;
    else if (ph_s <= 28'sd12582912) tri_v = 28'sd8388608 - ph_s;
    else tri_v = ph_s - 28'sd16777216;
  end

  always_comb begin
    if (pv > 32'sd16777216) pv_clamp = 26'sd16777216;
    else if (pv < -32'sd16777216) pv_clamp = -26'sd16777216;
    else pv_clamp = 26'(pv);
  end

  assign sine_addr = (op_r == OP_RD_PULSE) ? arg_r[29 -: SB] : phase_r[29 -: SB];

  // operand selection for the multiplier
  always_comb begin
    mreq.a   = '0;
    mreq.b   = '0;
    mreq.sh  = 6'd24;
    mreq.rnd = 1'b1;
    case (op_r)
      OP_DIV6: begin
        mreq.a = MUL_W'(div_u);  mreq.b = MUL_W'(DIV6_M);
        mreq.sh = 6'd25;         mreq.rnd = 1'b0;
      end
      OP_INTERP: begin
        mreq.a = signed'(MUL_W'(e1_r - e0_r));
        mreq.b = signed'(MUL_W'(exp_lo));
        mreq.sh = 6'(EXP_SH);    mreq.rnd = 1'b0;
      end
      OP_BASE: begin
        mreq.a = MUL_W'(C4_Q16); mreq.b = signed'(MUL_W'(mant_r));
        mreq.sh = 6'd32;         mreq.rnd = 1'b0;
      end
      OP_INC: begin
        mreq.a = signed'(MUL_W'(freq)); mreq.b = signed'(MUL_W'(period_r));
        mreq.sh = 6'd22;         mreq.rnd = 1'b0;
      end
      OP_SQ_A, OP_SQ_B: begin
        mreq.a = MUL_W'(v_r);    mreq.b = MUL_W'(v_r);
      end
      OP_CUBE_A, OP_CUBE_B: begin
        mreq.a = MUL_W'(v_r);    mreq.b = MUL_W'(RES_W'(K_484) - t_r);
      end
      OP_GAIN_A, OP_GAIN_B: begin
        mreq.a = MUL_W'(t_r);    mreq.b = MUL_W'(K_13);
      end
      OP_SAW_A: begin
        mreq.a = MUL_W'(saw_v) - MUL_W'(K_18);
        mreq.b = MUL_W'(saw_v) + MUL_W'(33554432);
      end
      OP_SAW_B: begin
        mreq.a = MUL_W'(saw_v);  mreq.b = MUL_W'(t_r);
      end
      OP_PH2: begin
        mreq.a = MUL_W'(ph_s);   mreq.b = MUL_W'(ph_s);
        mreq.rnd = 1'b0;
      end
      OP_ARG: begin
        mreq.a = MUL_W'(t_r);    mreq.b = MUL_W'(xw);
        mreq.sh = 6'd18;         mreq.rnd = 1'b0;
      end
      OP_TRI_A: begin
        mreq.a = MUL_W'(ph_s) - MUL_W'(16777216);
        mreq.b = MUL_W'(ph_s) <<< 1;
      end
      OP_TRI_B: begin
        mreq.a = MUL_W'(v50);    mreq.b = MUL_W'(t_r);
      end
      default: ;
    endcase
  end

  // result capture, at most one destination per micro-op
  always_ff @(posedge clk) begin
    if (cap) begin
      case (op_r)
        OP_DIV6:     tw_r   <= 21'(mres) - 21'sd262144;
        OP_RD_E0:    e0_r   <= exp_q;
        OP_RD_E1:    e1_r   <= exp_q;
        OP_INTERP:   mant_r <= e0_r + mres[33:0];
        OP_BASE:     base_r <= mres[26:0];
        OP_RD_SINE:  v_r    <= s24;
        OP_SQ_A, OP_SQ_B, OP_CUBE_A, OP_CUBE_B, OP_SAW_A, OP_PH2, OP_TRI_A:
                     t_r    <= mres;
        OP_GAIN_A:   sine_r <= to_out(50'(mres));
        OP_GAIN_B:   pulse_r <= to_out(50'(mres));
        OP_SAW_B:    saw_r  <= to_out(-(50'(mres) <<< 1));
        OP_ARG:      arg_r  <= mres[29:0];
        OP_RD_PULSE: v_r    <= pv_clamp;
        OP_TRI_B:    tri_r  <= to_out(50'(mres));
        default: ;
      endcase
    end
  end

  // phase: sync on transfer clears; INC steps, saturating, or clears at >= 2^30
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_xfer && fire) begin
      phase_r <= '0;
    end else if (cap && (op_r == OP_INC)) begin
      if (phase_r[31:30] != 2'b00) phase_r <= '0;
      else if (phase_sum[34:32] != 3'b000) phase_r <= 32'hFFFF_FFFF;
      else phase_r <= phase_sum[31:0];
    end
  end

  // output register
  logic     out_valid_r;
  wpo_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.sine_out     <= sine_r;
      out_data_r.saw_out      <= saw_r;
      out_data_r.pulse_out    <= pulse_r;
      out_data_r.triangle_out <= tri_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("block ready again right after an input transfer");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_HOLD))
    else $error("result raised outside the hold state");

  a_last_op_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cap && (op_r == OP_TRI_B)) |=> (state_r == ST_HOLD))
    else $error("sequencer did not stop after the last micro-op");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (sub_r == 2'd0))
    else $error("micro-op phase counter left running outside a sample");

endmodule
